@@ src/allca_pkg.sv @@
// Shared types and constants for the affinity least-load core assigner.
package allca_pkg;

    // Field widths of the item, result and configuration registers.
    localparam int INST_W     = 14;
    localparam int EXEC_W     = 12;
    localparam int DL_W       = 30;
    localparam int CAP_W      = 31;
    localparam int ACT_W      = 6;
    localparam int CORE_OUT_W = 5;
    localparam int LOAD_W     = 32;
    localparam int SUM_W      = LOAD_W + 1;
    localparam int SCAN_W     = ACT_W + 1;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CAP_W;

    // Number of distinct user instance codes on the input.
    localparam int INST_SPAN = 1 << INST_W;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CORES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 1'b1;
    localparam logic [ACT_W-1:0]     ACTIVE_RESET       = 6'd32;
    localparam logic [CAP_W-1:0]     CAP_RESET          = 31'h7FFF_FFFF;

    // Saturation value of a core load.
    localparam logic [LOAD_W-1:0] LOAD_MAX = 32'hFFFF_FFFF;

    // Item action code that starts a new batch.
    localparam logic ACT_CLEAR = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_REDUCE,
        ST_FETCH,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE
    } allca_state_t;

endpackage

@@ src/allca_if.sv @@
// Valid/ready channel interfaces for items and results of the core assigner.
interface allca_in_if;
    import allca_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [INST_W-1:0] user_instance;
    logic [EXEC_W-1:0] exec_time;
    logic [DL_W-1:0]   deadline;

    modport source (
        output valid, action, user_instance, exec_time, deadline,
        input  ready
    );
    modport sink (
        input  valid, action, user_instance, exec_time, deadline,
        output ready
    );
endinterface

interface allca_out_if;
    import allca_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CORE_OUT_W-1:0] assigned_core;
    logic                  from_affinity;
    logic                  fell_back;
    logic [LOAD_W-1:0]     core_load;

    modport source (
        output valid, assigned_core, from_affinity, fell_back, core_load,
        input  ready
    );
    modport sink (
        input  valid, assigned_core, from_affinity, fell_back, core_load,
        output ready
    );
endinterface

@@ src/allca_map_ram.sv @@
// Single write port, single registered read port RAM for the instance map.
module allca_map_ram #(
    parameter int DEPTH  = 16384,
    parameter int WIDTH  = 6,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ src/affinity_least_load_core_assigner.sv @@
// Top level of the affinity least-load core assigner.
//
// Items arrive on item_in (valid/ready). An assign item yields one result on
// result_out; a clear item yields none. Configuration is written through
// cfg_write_en/cfg_index/cfg_data; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// A small sequencer steps one item at a time through the instance map RAM
// and a single adder/comparator that walks the core loads one per cycle.
// An item whose instance is already mapped passes through the fetch,
// lookup and update steps; a new instance adds a scan over N cores, where
// N is active_cores capped at MAX_CORES. When INSTANCE_SLOTS is neither
// a power of two nor at least 16384, the slot is first reduced one bit
// per cycle. The next item is taken in the cycle after the result is
// registered. A clear item zeroes the loads at once, then sweeps the
// instance map one entry per cycle over all INSTANCE_SLOTS entries; the
// same sweep runs after reset. No item is taken during the sweep.
// A finished result waits in the output register; while the receiver
// stalls, the following item may be transferred and worked on, and it holds
// in its final step until the output register frees.
module affinity_least_load_core_assigner #(
    parameter int MAX_CORES      = 32,
    parameter int INSTANCE_SLOTS = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [allca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [allca_pkg::CFG_DATA_W-1:0] cfg_data,
    allca_in_if.sink                         item_in,
    allca_out_if.source                      result_out
);
    import allca_pkg::*;

    localparam int CORE_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int SLOT_W = $clog2(INSTANCE_SLOTS);
    localparam int MAP_W  = CORE_W + 1;
    localparam bit SLOT_POW2 = ((INSTANCE_SLOTS & (INSTANCE_SLOTS - 1)) == 0);
    localparam int MOD_STEPS = (SLOT_POW2 || INSTANCE_SLOTS >= INST_SPAN) ? 0 :
                               (INST_W + 1 - $clog2(INSTANCE_SLOTS));
    localparam logic [31:0] SLOT_MASK = SLOT_POW2 ? 32'(INSTANCE_SLOTS - 1) : {32{1'b1}};

    allca_state_t state_reg, state_next;

    logic [INST_W-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [EXEC_W-1:0]     exec_reg, exec_next;
    logic [DL_W-1:0]       dl_reg, dl_next;
    logic [CORE_W-1:0]     idx_reg, idx_next;
    logic [CORE_W-1:0]     core_reg, core_next;
    logic [CAP_W-1:0]      best_reg, best_next;
    logic                  found_reg, found_next;
    logic                  affinity_reg, affinity_next;
    logic [SLOT_W-1:0]     sweep_reg, sweep_next;
    logic [ACT_W-1:0]      active_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic [LOAD_W-1:0]     loads_reg [MAX_CORES];
    logic                  out_valid_reg, out_valid_next;
    logic [CORE_OUT_W-1:0] out_core_reg, out_core_next;
    logic                  out_aff_reg, out_aff_next;
    logic                  out_fell_reg, out_fell_next;
    logic [LOAD_W-1:0]     out_load_reg, out_load_next;

    logic              accept;
    logic              out_free;
    logic              finish;
    logic [31:0]       rem_ext;
    logic [31:0]       sub_val;
    logic [SLOT_W-1:0] slot;
    logic [SCAN_W-1:0] scan_cnt;
    logic              scan_last;
    logic [CORE_W-1:0] load_idx;
    logic [LOAD_W-1:0] load_sel;
    logic [SUM_W-1:0]  sum;
    logic              qualify;
    logic [LOAD_W-1:0] load_sat;
    logic              map_we;
    logic [SLOT_W-1:0] map_waddr;
    logic [MAP_W-1:0]  map_wdata;
    logic [MAP_W-1:0]  map_rdata;
    logic              map_hit;

    // Handshake qualifiers.
    assign accept   = item_in.valid && item_in.ready;
    assign out_free = !out_valid_reg || result_out.ready;
    assign finish   = (state_reg == ST_UPDATE) && out_free;

    // Map slot: mask for power-of-two maps, otherwise the reduced remainder.
    assign rem_ext = 32'(rem_reg);
    assign sub_val = 32'(INSTANCE_SLOTS) << step_reg;
    assign slot    = SLOT_W'(rem_ext & SLOT_MASK);

    // Number of cores walked by the scan.
    assign scan_cnt  = ({1'b0, active_reg} > SCAN_W'(MAX_CORES)) ?
                       SCAN_W'(MAX_CORES) : {1'b0, active_reg};
    assign scan_last = (SCAN_W'(idx_reg) + SCAN_W'(1)) == scan_cnt;

    // Shared load adder and candidate compare.
    assign load_idx = (state_reg == ST_SCAN) ? idx_reg : core_reg;
    assign load_sel = loads_reg[load_idx];
    assign sum      = {1'b0, load_sel} + SUM_W'(exec_reg);
    assign qualify  = (sum <= SUM_W'(dl_reg)) && (sum <= SUM_W'(cap_reg)) &&
                      (!found_reg || (sum < SUM_W'(best_reg)));
    assign load_sat = sum[SUM_W-1] ? LOAD_MAX : sum[LOAD_W-1:0];

    // Instance map storage and its write port selection.
    assign map_hit   = map_rdata[CORE_W];
    assign map_we    = (state_reg == ST_SWEEP) || (finish && !affinity_reg);
    assign map_waddr = (state_reg == ST_SWEEP) ? sweep_reg : slot;
    assign map_wdata = (state_reg == ST_SWEEP) ? '0 : {1'b1, core_reg};

    allca_map_ram #(
        .DEPTH  (INSTANCE_SLOTS),
        .WIDTH  (MAP_W),
        .ADDR_W (SLOT_W)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (slot),
        .rdata (map_rdata)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_reg == SLOT_W'(INSTANCE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_in.action == ACT_CLEAR)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (MOD_STEPS > 0)
                    begin
                        state_next = ST_REDUCE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (map_hit || (scan_cnt == '0))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result values per state.
    always_comb
    begin
        rem_next       = rem_reg;
        step_next      = step_reg;
        exec_next      = exec_reg;
        dl_next        = dl_reg;
        idx_next       = idx_reg;
        core_next      = core_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        affinity_next  = affinity_reg;
        sweep_next     = sweep_reg;
        out_core_next  = out_core_reg;
        out_aff_next   = out_aff_reg;
        out_fell_next  = out_fell_reg;
        out_load_next  = out_load_reg;
        out_valid_next = out_valid_reg;
        if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + SLOT_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next   = item_in.user_instance;
                    exec_next  = item_in.exec_time;
                    dl_next    = item_in.deadline;
                    step_next  = STEP_W'(MOD_STEPS - 1);
                    sweep_next = '0;
                end
            end
            ST_REDUCE:
            begin
                // One remainder bit per cycle, highest multiple first.
                if (rem_ext >= sub_val)
                begin
                    rem_next = INST_W'(rem_ext - sub_val);
                end
                step_next = step_reg - STEP_W'(1);
            end
            ST_LOOKUP:
            begin
                affinity_next = map_hit;
                found_next    = 1'b0;
                idx_next      = '0;
                core_next     = map_hit ? map_rdata[CORE_W-1:0] : '0;
            end
            ST_SCAN:
            begin
                if (qualify)
                begin
                    found_next = 1'b1;
                    best_next  = sum[CAP_W-1:0];
                    core_next  = idx_reg;
                end
                idx_next = idx_reg + CORE_W'(1);
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_core_next  = CORE_OUT_W'(core_reg);
                    out_aff_next   = affinity_reg;
                    out_fell_next  = !affinity_reg && !found_reg;
                    out_load_next  = load_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Input channel is open only between items.
    always_comb
    begin
        item_in.ready = (state_reg == ST_IDLE);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            affinity_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            affinity_reg  <= affinity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        exec_reg     <= exec_next;
        dl_reg       <= dl_next;
        core_reg     <= core_next;
        best_reg     <= best_next;
        out_core_reg <= out_core_next;
        out_aff_reg  <= out_aff_next;
        out_fell_reg <= out_fell_next;
        out_load_reg <= out_load_next;
    end

    // Core loads: cleared by reset and by a clear item, updated on finish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CORES; i++)
            begin
                loads_reg[i] <= '0;
            end
        end
        else if (accept && (item_in.action == ACT_CLEAR))
        begin
            for (int i = 0; i < MAX_CORES; i++)
            begin
                loads_reg[i] <= '0;
            end
        end
        else if (finish)
        begin
            loads_reg[core_reg] <= load_sat;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            cap_reg    <= CAP_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_ACTIVE_CORES)
            begin
                active_reg <= cfg_data[ACT_W-1:0];
            end
            if (cfg_index == REG_CAPACITY_LIMIT)
            begin
                cap_reg <= cfg_data[CAP_W-1:0];
            end
        end
    end

    // Result channel outputs.
    assign result_out.valid         = out_valid_reg;
    assign result_out.assigned_core = out_core_reg;
    assign result_out.from_affinity = out_aff_reg;
    assign result_out.fell_back     = out_fell_reg;
    assign result_out.core_load     = out_load_reg;

`ifndef SYNTHESIS
    // The scan never walks past the active core count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ((SCAN_W'(idx_reg) + SCAN_W'(1)) <= scan_cnt))
        else $error("scan index beyond active cores");

    // A fallback result goes to core 0 and never comes from affinity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.fell_back) |->
        ((result_out.assigned_core == '0) && !result_out.from_affinity))
        else $error("fallback result not on core 0");

    // A new result appears only out of the final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_UPDATE))
        else $error("result valid raised outside final step");

    // A clear item empties the loads and starts the map sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item_in.action == ACT_CLEAR)) |=>
        ((state_reg == ST_SWEEP) && (sweep_reg == '0) && (loads_reg[0] == '0)))
        else $error("clear item did not start a new batch");
`endif
endmodule
